// ===== sv/projected_spatial_sort_query_defines.svh =====
// Shared assertion macros for the spatial sort query block.
`ifndef PROJECTED_SPATIAL_SORT_QUERY_DEFINES_SVH
`define PROJECTED_SPATIAL_SORT_QUERY_DEFINES_SVH

// Checks that a consequent holds in the same cycle as its antecedent.
`define SSQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define SSQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/ssq_pkg.sv =====
package ssq_pkg;

  // Store geometry.
  localparam int CAPACITY    = 1024;
  localparam int MAX_MATCHES = 64;
  localparam int AW          = $clog2(CAPACITY);
  localparam int CW          = $clog2(CAPACITY + 1);
  localparam int NW          = $clog2(MAX_MATCHES + 1);
  localparam int DW          = 40;
  localparam int QDEPTH      = 4;
  localparam int QAW         = $clog2(QDEPTH);
  localparam int QCW         = $clog2(QDEPTH + 1);

  // Configuration register indexes.
  localparam logic [1:0] REG_NORMAL_X = 2'd0;
  localparam logic [1:0] REG_NORMAL_Y = 2'd1;
  localparam logic [1:0] REG_NORMAL_Z = 2'd2;

  // Request codes on the input side.
  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_SORT   = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_NOT_SORTED = 2'd2,
    ST_TRUNC      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    K_APPEND = 2'd0,
    K_SORT   = 2'd1,
    K_QUERY  = 2'd2,
    K_NOP    = 2'd3
  } kind_t;

  // One classified command travelling from front to back.
  typedef struct packed {
    kind_t              kind;
    logic               sort_after;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        vertex_index;
    logic [30:0]        tolerance;
  } cmd_t;

  // Plane normal from the register bank.
  typedef struct packed {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
  } normal_t;

  // One stored vertex.
  typedef struct packed {
    logic signed [31:0]   x;
    logic signed [31:0]   y;
    logic signed [31:0]   z;
    logic [31:0]          idx;
    logic signed [DW-1:0] proj_dist;
  } rec_t;

endpackage

// ===== sv/ssq_front.sv =====
module ssq_front
  import ssq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [159:0] in_tdata,
  input  logic [2:0]   in_tuser,
  input  logic         in_tlast,
  output cmd_t         cmd,
  output logic         cmd_valid,
  input  logic         cmd_pop
);

  cmd_t             q_r [QDEPTH];
  logic [QAW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCW-1:0]   cnt_r, cnt_nxt;
  cmd_t             cls;
  logic             push, pop;

  // Classify the incoming word.
  always_comb begin
    cls.sort_after   = in_tlast & in_tuser[2];
    cls.pos_x        = in_tdata[31:0];
    cls.pos_y        = in_tdata[63:32];
    cls.pos_z        = in_tdata[95:64];
    cls.vertex_index = in_tdata[127:96];
    cls.tolerance    = in_tdata[158:128];
    case (in_tuser[1:0])
      REQ_APPEND: cls.kind = K_APPEND;
      REQ_SORT:   cls.kind = K_SORT;
      REQ_QUERY:  cls.kind = K_QUERY;
      default:    cls.kind = K_NOP;
    endcase
  end

  assign in_tready = (cnt_r != QCW'(QDEPTH));
  assign push      = in_tvalid & in_tready;
  assign cmd_valid = (cnt_r != '0);
  assign pop       = cmd_pop & cmd_valid;
  assign cmd       = q_r[rp_r];

  // Queue pointers.
  always_comb begin
    wp_nxt  = push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + QCW'(push) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= cls;
    end
  end

endmodule

// ===== sv/ssq_back.sv =====
module ssq_back
  import ssq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  normal_t     nrm,
  input  cmd_t        cmd,
  input  logic        cmd_valid,
  output logic        cmd_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  output logic [2:0]  out_tuser,
  output logic        out_tlast
);

  typedef enum logic [17:0] {
    S_IDLE  = 18'h00001,
    S_RESP  = 18'h00002,
    S_DRD   = 18'h00004,
    S_DWAIT = 18'h00008,
    S_DSUM  = 18'h00010,
    S_IRD   = 18'h00020,
    S_ILOAD = 18'h00040,
    S_ICRD  = 18'h00080,
    S_ICMP  = 18'h00100,
    S_QMUL  = 18'h00200,
    S_QSUM  = 18'h00400,
    S_BS    = 18'h00800,
    S_BSCMP = 18'h01000,
    S_SRD   = 18'h02000,
    S_SDIFF = 18'h04000,
    S_SSQ   = 18'h08000,
    S_STEST = 18'h10000,
    S_QEND  = 18'h20000
  } state_t;

  // Vertex store.
  rec_t           mem [CAPACITY];
  rec_t           rd_data_r;
  logic           rd_en, wr_en;
  logic [AW-1:0]  rd_addr, wr_addr;
  rec_t           wr_data;

  state_t              state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  status_t             st_r, st_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                sorted_r, sorted_nxt;
  logic [CW-1:0]       i_r, i_nxt, j_r, j_nxt;
  logic [CW-1:0]       lo_r, lo_nxt, hi_r, hi_nxt, mid_r, mid_nxt;
  rec_t                tmp_r, tmp_nxt;
  logic signed [47:0]  px_r, py_r, pz_r, px_nxt, py_nxt, pz_nxt;
  logic signed [40:0]  lod_r, lod_nxt, hid_r, hid_nxt;
  logic [61:0]         tsq_r, tsq_nxt;
  logic [32:0]         dx_r, dy_r, dz_r, dx_nxt, dy_nxt, dz_nxt;
  logic [61:0]         sx_r, sy_r, sz_r, sx_nxt, sy_nxt, sz_nxt;
  logic [31:0]         cidx_r, cidx_nxt, pidx_r, pidx_nxt;
  logic                pend_r, pend_nxt, trunc_r, trunc_nxt;
  logic [NW-1:0]       n_r, n_nxt;

  logic                ov_r, ov_nxt, omv_r, omv_nxt, olast_r, olast_nxt;
  logic [31:0]         oidx_r, oidx_nxt;
  status_t             ost_r, ost_nxt;
  logic                out_free;

  logic signed [49:0]  psum;
  logic signed [DW-1:0] proj;
  logic signed [40:0]  tol41, rdist41;
  logic signed [32:0]  ddx, ddy, ddz;
  logic [32:0]         tol33;
  logic [63:0]         sqsum;
  logic [CW:0]         mid_sum;

  // Projection sum and floor division by 2^14.
  assign psum    = 50'(px_r) + 50'(py_r) + 50'(pz_r);
  assign proj    = DW'(psum >>> 14);
  assign tol41   = $signed({10'b0, cmd_r.tolerance});
  assign tol33   = {2'b0, cmd_r.tolerance};
  assign rdist41 = 41'(rd_data_r.proj_dist);
  assign ddx     = 33'(rd_data_r.x) - 33'(cmd_r.pos_x);
  assign ddy     = 33'(rd_data_r.y) - 33'(cmd_r.pos_y);
  assign ddz     = 33'(rd_data_r.z) - 33'(cmd_r.pos_z);
  assign sqsum   = 64'(sx_r) + 64'(sy_r) + 64'(sz_r);
  assign mid_sum = (CW+1)'(lo_r) + (CW+1)'(hi_r);
  assign out_free = !ov_r || out_tready;

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    st_nxt     = st_r;
    count_nxt  = count_r;
    sorted_nxt = sorted_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    tmp_nxt    = tmp_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    pz_nxt     = pz_r;
    lod_nxt    = lod_r;
    hid_nxt    = hid_r;
    tsq_nxt    = tsq_r;
    dx_nxt     = dx_r;
    dy_nxt     = dy_r;
    dz_nxt     = dz_r;
    sx_nxt     = sx_r;
    sy_nxt     = sy_r;
    sz_nxt     = sz_r;
    cidx_nxt   = cidx_r;
    pidx_nxt   = pidx_r;
    pend_nxt   = pend_r;
    trunc_nxt  = trunc_r;
    n_nxt      = n_r;
    ov_nxt     = ov_r && !out_tready;
    omv_nxt    = omv_r;
    olast_nxt  = olast_r;
    oidx_nxt   = oidx_r;
    ost_nxt    = ost_r;
    cmd_pop    = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = rd_data_r;

    case (state_r)
      // Take the next command and dispatch it.
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          st_nxt  = ST_OK;
          case (cmd.kind)
            K_APPEND: begin
              if (count_r < CW'(CAPACITY)) begin
                wr_en             = 1'b1;
                wr_addr           = count_r[AW-1:0];
                wr_data.x         = cmd.pos_x;
                wr_data.y         = cmd.pos_y;
                wr_data.z         = cmd.pos_z;
                wr_data.idx       = cmd.vertex_index;
                wr_data.proj_dist = '0;
                count_nxt         = count_r + 1'b1;
                sorted_nxt        = 1'b0;
              end else begin
                st_nxt = ST_FULL;
              end
              i_nxt     = '0;
              state_nxt = cmd.sort_after ? S_DRD : S_RESP;
            end
            K_SORT: begin
              i_nxt     = '0;
              state_nxt = S_DRD;
            end
            K_QUERY: begin
              if (sorted_r) begin
                state_nxt = S_QMUL;
              end else begin
                st_nxt    = ST_NOT_SORTED;
                state_nxt = S_RESP;
              end
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end

      // Single result word for append, sort and request errors.
      S_RESP: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          omv_nxt   = 1'b0;
          oidx_nxt  = '0;
          ost_nxt   = st_r;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      // Distance pass: recompute each entry with the current normal.
      S_DRD: begin
        if (i_r >= count_r) begin
          i_nxt     = CW'(1);
          state_nxt = S_IRD;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = i_r[AW-1:0];
          state_nxt = S_DWAIT;
        end
      end
      S_DWAIT: begin
        px_nxt    = nrm.nx * rd_data_r.x;
        py_nxt    = nrm.ny * rd_data_r.y;
        pz_nxt    = nrm.nz * rd_data_r.z;
        state_nxt = S_DSUM;
      end
      S_DSUM: begin
        wr_en             = 1'b1;
        wr_addr           = i_r[AW-1:0];
        wr_data.proj_dist = proj;
        i_nxt             = i_r + 1'b1;
        state_nxt         = S_DRD;
      end

      // Stable insertion sort over the store.
      S_IRD: begin
        if (i_r >= count_r) begin
          sorted_nxt = 1'b1;
          state_nxt  = S_RESP;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = i_r[AW-1:0];
          state_nxt = S_ILOAD;
        end
      end
      S_ILOAD: begin
        tmp_nxt   = rd_data_r;
        j_nxt     = i_r;
        state_nxt = S_ICRD;
      end
      S_ICRD: begin
        if (j_r == '0) begin
          wr_en     = 1'b1;
          wr_addr   = j_r[AW-1:0];
          wr_data   = tmp_r;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_IRD;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = AW'(j_r - 1'b1);
          state_nxt = S_ICMP;
        end
      end
      S_ICMP: begin
        wr_en   = 1'b1;
        wr_addr = j_r[AW-1:0];
        if (rd_data_r.proj_dist > tmp_r.proj_dist) begin
          wr_data   = rd_data_r;
          j_nxt     = j_r - 1'b1;
          state_nxt = S_ICRD;
        end else begin
          wr_data   = tmp_r;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_IRD;
        end
      end

      // Query: project the query point and set the distance window.
      S_QMUL: begin
        px_nxt    = nrm.nx * cmd_r.pos_x;
        py_nxt    = nrm.ny * cmd_r.pos_y;
        pz_nxt    = nrm.nz * cmd_r.pos_z;
        state_nxt = S_QSUM;
      end
      S_QSUM: begin
        lod_nxt   = 41'(proj) - tol41;
        hid_nxt   = 41'(proj) + tol41;
        tsq_nxt   = cmd_r.tolerance * cmd_r.tolerance;
        lo_nxt    = '0;
        hi_nxt    = count_r;
        pend_nxt  = 1'b0;
        trunc_nxt = 1'b0;
        n_nxt     = '0;
        state_nxt = S_BS;
      end

      // Binary search for the first distance at or above the window start.
      S_BS: begin
        if (lo_r < hi_r) begin
          mid_nxt   = mid_sum[CW:1];
          rd_en     = 1'b1;
          rd_addr   = mid_sum[AW:1];
          state_nxt = S_BSCMP;
        end else begin
          i_nxt     = lo_r;
          state_nxt = S_SRD;
        end
      end
      S_BSCMP: begin
        if (rdist41 < lod_r) begin
          lo_nxt = mid_r + 1'b1;
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = S_BS;
      end

      // Forward scan through the window.
      S_SRD: begin
        if (i_r >= count_r) begin
          state_nxt = S_QEND;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = i_r[AW-1:0];
          state_nxt = S_SDIFF;
        end
      end
      S_SDIFF: begin
        if (rdist41 >= hid_r) begin
          state_nxt = S_QEND;
        end else begin
          dx_nxt    = ddx[32] ? 33'(-ddx) : 33'(ddx);
          dy_nxt    = ddy[32] ? 33'(-ddy) : 33'(ddy);
          dz_nxt    = ddz[32] ? 33'(-ddz) : 33'(ddz);
          cidx_nxt  = rd_data_r.idx;
          state_nxt = S_SSQ;
        end
      end
      S_SSQ: begin
        if (dx_r > tol33 || dy_r > tol33 || dz_r > tol33) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SRD;
        end else begin
          sx_nxt    = dx_r[30:0] * dx_r[30:0];
          sy_nxt    = dy_r[30:0] * dy_r[30:0];
          sz_nxt    = dz_r[30:0] * dz_r[30:0];
          state_nxt = S_STEST;
        end
      end
      S_STEST: begin
        if (sqsum > 64'(tsq_r)) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SRD;
        end else if (n_r >= NW'(MAX_MATCHES)) begin
          trunc_nxt = 1'b1;
          state_nxt = S_QEND;
        end else if (!pend_r) begin
          pend_nxt  = 1'b1;
          pidx_nxt  = cidx_r;
          n_nxt     = n_r + 1'b1;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SRD;
        end else if (out_free) begin
          // Release the held match now that another one follows it.
          ov_nxt    = 1'b1;
          omv_nxt   = 1'b1;
          oidx_nxt  = pidx_r;
          ost_nxt   = ST_OK;
          olast_nxt = 1'b0;
          pidx_nxt  = cidx_r;
          n_nxt     = n_r + 1'b1;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_SRD;
        end
      end

      // Final word of a query.
      S_QEND: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          omv_nxt   = pend_r;
          oidx_nxt  = pend_r ? pidx_r : '0;
          ost_nxt   = trunc_r ? ST_TRUNC : ST_OK;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      sorted_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      sorted_r <= sorted_nxt;
      ov_r     <= ov_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    st_r    <= st_nxt;
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    tmp_r   <= tmp_nxt;
    px_r    <= px_nxt;
    py_r    <= py_nxt;
    pz_r    <= pz_nxt;
    lod_r   <= lod_nxt;
    hid_r   <= hid_nxt;
    tsq_r   <= tsq_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    dz_r    <= dz_nxt;
    sx_r    <= sx_nxt;
    sy_r    <= sy_nxt;
    sz_r    <= sz_nxt;
    cidx_r  <= cidx_nxt;
    pidx_r  <= pidx_nxt;
    pend_r  <= pend_nxt;
    trunc_r <= trunc_nxt;
    n_r     <= n_nxt;
    omv_r   <= omv_nxt;
    olast_r <= olast_nxt;
    oidx_r  <= oidx_nxt;
    ost_r   <= ost_nxt;
  end

  // Store memory with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = oidx_r;
  assign out_tuser  = {ost_r, omv_r};
  assign out_tlast  = olast_r;

endmodule

// ===== sv/projected_spatial_sort_query.sv =====
// Projected spatial sort and radius query. Appends, sort and query requests
// enter a four-word command queue and are carried out one at a time by a
// sequencer that owns the vertex store (at most one read or one write per
// cycle). A sort first recomputes all stored distances and then runs an
// insertion pass; a query runs a binary search and then scans the entries in
// the distance window. Results leave through a one-word output register; a
// query holds back each match until it knows whether another follows, so it
// can mark the final word. The store needs no clearing pass after reset.
module projected_spatial_sort_query
  import ssq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [159:0] in_tdata,  // pos_x, pos_y, pos_z, vertex_index, tolerance
  input  logic [2:0]   in_tuser,  // req_type, sort_after
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata, // match_index
  output logic [2:0]   out_tuser, // match_valid, status
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_wdata
);

`include "projected_spatial_sort_query_defines.svh"

  normal_t normal_r, normal_nxt;
  cmd_t    cmd;
  logic    cmd_valid, cmd_pop;
  logic    out_trunc_word, out_err_word;

  // Plane normal registers.
  always_comb begin
    normal_nxt = normal_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_NORMAL_X: normal_nxt.nx = cfg_wdata;
        REG_NORMAL_Y: normal_nxt.ny = cfg_wdata;
        REG_NORMAL_Z: normal_nxt.nz = cfg_wdata;
        default:      normal_nxt = normal_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      normal_r.nx <= 16'sd16384;
      normal_r.ny <= '0;
      normal_r.nz <= '0;
    end else begin
      normal_r <= normal_nxt;
    end
  end

  ssq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  ssq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .nrm        (normal_r),
    .cmd        (cmd),
    .cmd_valid  (cmd_valid),
    .cmd_pop    (cmd_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Status decodes for the checks below.
  assign out_trunc_word = out_tvalid && (out_tuser[2:1] == ST_TRUNC);
  assign out_err_word   = out_tvalid &&
                          (out_tuser[2:1] == ST_FULL || out_tuser[2:1] == ST_NOT_SORTED);

  // A word without a match carries a zero index.
  `SSQ_ASSERT_IMP(a_no_match_zero, out_tvalid && !out_tuser[0], out_tdata == '0, "index without match")
  // A truncated query ends on a real match.
  `SSQ_ASSERT_IMP(a_trunc_last, out_trunc_word, out_tuser[0] && out_tlast, "bad truncation word")
  // Error words are single and carry no match.
  `SSQ_ASSERT_IMP(a_err_single, out_err_word, out_tlast && !out_tuser[0], "bad error word")

endmodule

// ===== tb/ssq_match_checker.sv =====
`timescale 1ns / 100ps

module ssq_match_checker
  import ssq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [159:0] in_tdata,  // pos_x, pos_y, pos_z, vertex_index, tolerance
  input  logic [2:0]   in_tuser,  // req_type, sort_after
  input  logic         in_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [31:0]  out_tdata, // match_index
  input  logic [2:0]   out_tuser, // match_valid, status
  input  logic         out_tlast,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_wdata,
  output int           fail_count,
  output int           words_pending
);

  typedef struct {
    logic [31:0] idx;
    logic        valid;
    status_t     st;
    logic        last;
  } result_word_t;

  result_word_t want_q[$];

  logic signed [15:0] nrm_x, nrm_y, nrm_z;
  longint             vx[CAPACITY];
  longint             vy[CAPACITY];
  longint             vz[CAPACITY];
  longint             vdist[CAPACITY];
  logic [31:0]        vidx[CAPACITY];
  int                 vcount;
  bit                 vsorted;

  assign words_pending = want_q.size();

  // Signed distance along the Q2.14 normal, floored to whole coordinate units.
  function automatic longint project_distance(longint x, longint y, longint z);
    longint s;
    s = longint'(nrm_x) * x + longint'(nrm_y) * y + longint'(nrm_z) * z;
    return s >>> 14;
  endfunction

  function automatic longint abs_gap(longint a, longint b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic void push_word(logic [31:0] idx, logic valid, status_t st, logic last);
    result_word_t w;
    w.idx = idx;
    w.valid = valid;
    w.st = st;
    w.last = last;
    want_q = {want_q, w};
  endfunction

  // Stable insertion sort on freshly projected distances.
  function automatic void sort_by_distance();
    longint tx, ty, tz, td;
    logic [31:0] ti;
    int j;
    for (int i = 0; i < vcount; i++) vdist[i] = project_distance(vx[i], vy[i], vz[i]);
    for (int i = 1; i < vcount; i++) begin
      tx = vx[i]; ty = vy[i]; tz = vz[i]; td = vdist[i]; ti = vidx[i];
      j = i;
      while (j > 0 && vdist[j-1] > td) begin
        vx[j] = vx[j-1]; vy[j] = vy[j-1]; vz[j] = vz[j-1];
        vdist[j] = vdist[j-1]; vidx[j] = vidx[j-1];
        j--;
      end
      vx[j] = tx; vy[j] = ty; vz[j] = tz; vdist[j] = td; vidx[j] = ti;
    end
    vsorted = 1;
  endfunction

  // Radius query: binary search for the window start, then scan it.
  function automatic void run_query(longint x, longint y, longint z, longint tol);
    longint d, lo_d, hi_d, dx, dy, dz;
    logic [65:0] sq, tsq;
    int lo, hi, mid, n;
    bit trunc;
    logic [31:0] hits[$];
    if (!vsorted) begin
      push_word(0, 0, ST_NOT_SORTED, 1);
      return;
    end
    d = project_distance(x, y, z);
    lo_d = d - tol;
    hi_d = d + tol;
    lo = 0;
    hi = vcount;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (vdist[mid] < lo_d) lo = mid + 1;
      else hi = mid;
    end
    trunc = 0;
    tsq = 66'(tol) * 66'(tol);
    for (int e = lo; e < vcount; e++) begin
      if (vdist[e] >= hi_d) break;
      dx = abs_gap(vx[e], x);
      dy = abs_gap(vy[e], y);
      dz = abs_gap(vz[e], z);
      if (dx > tol || dy > tol || dz > tol) continue;
      sq = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy) + 66'(dz) * 66'(dz);
      if (sq > tsq) continue;
      if (hits.size() >= MAX_MATCHES) begin
        trunc = 1;
        break;
      end
      hits = {hits, vidx[e]};
    end
    n = hits.size();
    if (n == 0) begin
      push_word(0, 0, ST_OK, 1);
      return;
    end
    for (int k = 0; k < n; k++)
      push_word(hits[k], 1, (k == n - 1 && trunc) ? ST_TRUNC : ST_OK, k == n - 1);
  endfunction

  function automatic void predict_request(logic [1:0] req, logic [159:0] data,
                                          logic sort_after, logic last_in_batch);
    longint x, y, z;
    status_t st;
    x = longint'(signed'(data[31:0]));
    y = longint'(signed'(data[63:32]));
    z = longint'(signed'(data[95:64]));
    case (req)
      REQ_APPEND: begin
        st = ST_OK;
        if (vcount < CAPACITY) begin
          vx[vcount] = x;
          vy[vcount] = y;
          vz[vcount] = z;
          vidx[vcount] = data[127:96];
          vcount++;
          vsorted = 0;
        end else begin
          st = ST_FULL;
        end
        if (last_in_batch && sort_after) sort_by_distance();
        push_word(0, 0, st, 1);
      end
      REQ_SORT: begin
        sort_by_distance();
        push_word(0, 0, ST_OK, 1);
      end
      REQ_QUERY: run_query(x, y, z, longint'(data[158:128]));
      default: push_word(0, 0, ST_OK, 1);
    endcase
  endfunction

  // Track configuration, predict on accepted words, compare on results.
  always @(posedge clk) begin
    result_word_t w;
    if (!rst_n) begin
      nrm_x = 16'sd16384;
      nrm_y = 16'sd0;
      nrm_z = 16'sd0;
      vcount = 0;
      vsorted = 0;
      fail_count <= 0;
      want_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NORMAL_X: nrm_x = cfg_wdata;
          REG_NORMAL_Y: nrm_y = cfg_wdata;
          REG_NORMAL_Z: nrm_z = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        predict_request(in_tuser[1:0], in_tdata, in_tuser[2], in_tlast);
      if (out_tvalid && out_tready) begin
        if (want_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result word with nothing expected: idx=%h user=%b last=%b",
                     $time, out_tdata, out_tuser, out_tlast);
          fail_count <= fail_count + 1;
        end else begin
          w = want_q.pop_front();
          if (out_tdata !== w.idx || out_tuser[0] !== w.valid ||
              out_tuser[2:1] !== w.st || out_tlast !== w.last) begin
            if (fail_count < 10)
              $display("%0t: mismatch: want idx=%h valid=%b status=%0d last=%b, %s",
                       $time, w.idx, w.valid, w.st, w.last,
                       $sformatf("got idx=%h valid=%b status=%0d last=%b",
                                 out_tdata, out_tuser[0], out_tuser[2:1], out_tlast));
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_projected_spatial_sort_query.sv =====
`timescale 1ns / 100ps

module tb_projected_spatial_sort_query;
  import ssq_pkg::*;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [159:0] in_tdata = '0;  // pos_x, pos_y, pos_z, vertex_index, tolerance
  logic [2:0]   in_tuser = '0;  // req_type, sort_after
  logic         in_tlast = 0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [31:0]  out_tdata;      // match_index
  logic [2:0]   out_tuser;      // match_valid, status
  logic         out_tlast;
  logic         cfg_we = 0;
  logic [1:0]   cfg_index = '0;
  logic [15:0]  cfg_wdata = '0;

  int fail_count;
  int words_pending;
  bit no_idle = 0;
  int entries = 0;
  int item_count = 0;
  logic [31:0] known_x[$], known_y[$], known_z[$];
  int unsigned index_base = 0;
  logic [3:0] out_stall = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  projected_spatial_sort_query uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  ssq_match_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .words_pending(words_pending)
  );

  // Result side: after each accepted word, may drop out_tready for a random stall unless no_idle is set.
  always @(posedge clk) begin
    int w;
    if (!rst_n) begin
      out_tready <= 0;
      out_stall <= 0;
    end else if (out_tready) begin
      if (out_tvalid) begin
        w = no_idle ? 0 : $urandom_range(0, 9);
        if (w != 0) begin
          out_tready <= 0;
          out_stall <= 4'(w);
        end
      end
    end else if (out_stall <= 1) begin
      out_tready <= 1;
    end else begin
      out_stall <= out_stall - 1'b1;
    end
  end

  // Send one word and wait for its acceptance.
  task automatic send_word(logic [1:0] req, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                           logic [31:0] vidx, logic last_b, logic srt, logic [30:0] tol);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {1'b0, tol, vidx, z, y, x};
    in_tuser <= {srt, req};
    in_tlast <= last_b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    item_count++;
    if (req == REQ_APPEND) begin
      if (entries < CAPACITY) entries++;
      known_x = {known_x, x};
      known_y = {known_y, y};
      known_z = {known_z, z};
    end
  endtask

  // Write all three normal components once the block has drained.
  task automatic write_normal(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz);
    in_tvalid <= 0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1; cfg_index <= REG_NORMAL_X; cfg_wdata <= nx;
    @(posedge clk);
    cfg_index <= REG_NORMAL_Y; cfg_wdata <= ny;
    @(posedge clk);
    cfg_index <= REG_NORMAL_Z; cfg_wdata <= nz;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [30:0] pick_tolerance();
    case ($urandom_range(0, 5))
      0: return 31'd0;
      1: return 31'($urandom_range(1, 255));
      2: return 31'((1 << $urandom_range(8, 22)) + $urandom_range(0, 4095));
      3: return 31'($urandom);
      4: return 31'h7FFFFFFF;
      default: return 31'((1 << $urandom_range(14, 18)));
    endcase
  endfunction

  function automatic logic [31:0] jitter();
    return 32'(($urandom_range(0, 2047) - 1024) <<< $urandom_range(0, 12));
  endfunction

  // Query aimed near a stored vertex so that matches are frequent.
  task automatic near_query();
    int k;
    if (known_x.size() == 0 || $urandom_range(0, 9) == 0) begin
      send_word(REQ_QUERY, $urandom, $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), pick_tolerance());
    end else begin
      k = $urandom_range(0, known_x.size() - 1);
      send_word(REQ_QUERY, known_x[k] + jitter(), known_y[k] + jitter(),
                known_z[k] + jitter(), $urandom, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), pick_tolerance());
    end
  endtask

  // A batch of clustered vertices, usually closed with a sort.
  task automatic append_batch();
    int n;
    logic [31:0] cx, cy, cz;
    n = $urandom_range(1, 6);
    cx = 32'($urandom_range(0, 32'h7FFFFFFF)) - 32'h40000000;
    cy = 32'($urandom_range(0, 32'h7FFFFFFF)) - 32'h40000000;
    cz = 32'($urandom_range(0, 32'h7FFFFFFF)) - 32'h40000000;
    for (int k = 0; k < n; k++)
      send_word(REQ_APPEND, cx + jitter(), cy + jitter(), cz + jitter(), index_base + k,
                k == n - 1,
                (k == n - 1) ? ($urandom_range(0, 9) < 7) : 1'($urandom_range(0, 1)),
                31'($urandom));
    index_base += n;
  endtask

  task automatic random_phase(int count);
    int r, stop_at;
    stop_at = item_count + count;
    while (item_count < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 10) no_idle = ~no_idle;
      if (r < 45 && entries < 200) append_batch();
      else if (r < 80) near_query();
      else if (r < 88) send_word(REQ_SORT, $urandom, $urandom, $urandom, $urandom,
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 31'($urandom));
      else if (r < 93) send_word(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom,
                                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                 31'($urandom));
      else if (entries < 200) send_word(REQ_APPEND, $urandom, $urandom, $urandom, $urandom,
                                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                        31'($urandom));
      else near_query();
    end
    no_idle = 0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: query before sort, unused code, extremes, ties, tolerance edges.
    send_word(REQ_QUERY, 0, 0, 0, 0, 0, 0, 31'h7FFFFFFF);
    send_word(REQ_UNUSED, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 1,
              31'h7FFFFFFF);
    send_word(REQ_APPEND, 32'h7FFFFFFF, 32'h80000000, 0, 32'hFFFFFFFF, 0, 1, 0);
    send_word(REQ_APPEND, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 0);
    send_word(REQ_APPEND, 0, 0, 0, 32'd5, 0, 0, 0);
    send_word(REQ_APPEND, 0, 0, 0, 32'd6, 1, 1, 0);
    send_word(REQ_QUERY, 0, 0, 0, 0, 0, 0, 31'd0);
    send_word(REQ_QUERY, 0, 0, 0, 0, 0, 0, 31'h7FFFFFFF);
    send_word(REQ_QUERY, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 0, 31'd1);
    send_word(REQ_APPEND, 32'h00010000, 0, 0, 32'd7, 1, 0, 0);
    send_word(REQ_QUERY, 0, 0, 0, 0, 0, 0, 31'h00010000);
    send_word(REQ_SORT, 0, 0, 0, 0, 0, 0, 0);
    send_word(REQ_SORT, 0, 0, 0, 0, 0, 0, 0);
    send_word(REQ_QUERY, 0, 0, 0, 0, 0, 0, 31'h00010001);
    send_word(REQ_QUERY, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 31'h7FFFFFFF);

    // Normal changed after sorting keeps the store sorted.
    write_normal(16'h7FFF, 16'h8000, 16'h0001);
    send_word(REQ_QUERY, 0, 0, 0, 0, 0, 0, 31'h00100000);

    // Dense cluster to overflow the match limit.
    for (int k = 0; k < 70; k++)
      send_word(REQ_APPEND, 32'h00640000, 32'hFF9C0000, 32'h00320000, 32'h1000 + k,
                k == 69, k == 69, 31'($urandom));
    send_word(REQ_QUERY, 32'h00640000, 32'hFF9C0000, 32'h00320000, 0, 0, 0, 31'h00010000);
    index_base = 32'h2000;
    random_phase(50);

    write_normal(16'h8000, 16'h7FFF, 16'h8000);
    send_word(REQ_SORT, 0, 0, 0, 0, 0, 0, 0);
    random_phase(50);

    write_normal(16'h0000, 16'h4000, 16'hC000);
    random_phase(50);

    write_normal(16'($urandom), 16'($urandom), 16'($urandom));
    random_phase(50);

    in_tvalid <= 0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_projected_spatial_sort_query: PASS");
    end else begin
      $display("tb_projected_spatial_sort_query: FAIL");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("tb_projected_spatial_sort_query: FAIL");
    $finish;
  end

endmodule
